/* design/cbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, sizes and helper functions for the circular buffer deque.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Number of slots in the circular store.
  localparam int unsigned Depth = 8;
  // Width of a slot index and of the entry counter (which must hold Depth).
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned OpW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned EntryW = 4;

  // Stream word widths, packed fields padded up to whole bytes.
  localparam int unsigned InFieldsW = OpW + DataW;
  localparam int unsigned InTdataW = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = StatusW + DataW + EntryW;
  localparam int unsigned OutTdataW = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Slot index one step towards the rear, wrapping after the last slot.
  function automatic logic [AddrW-1:0] step_up(input logic [AddrW-1:0] idx);
    return (idx >= LastIdx) ? '0 : AddrW'(idx + 1'b1);
  endfunction

  // Slot index one step towards the front, wrapping below slot zero.
  function automatic logic [AddrW-1:0] step_down(input logic [AddrW-1:0] idx);
    return (idx == '0 || idx > LastIdx) ? LastIdx : AddrW'(idx - 1'b1);
  endfunction

endpackage
`default_nettype wire

/* design/circular_buffer_deque_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_buffer_deque_unit
// Double-ended queue of signed 32-bit words held in a circular RAM.
// ----------------------------------------------------------------------------
// Each input word carries an opcode (push front, push rear, pop front, pop
// rear) and a value, and produces exactly one output word with a status
// (done, push refused because full, pop refused because empty), the popped
// value (zero unless a pop succeeded) and the entry count after the operation.
// The unit takes one word per cycle unless the output stalls: the head, tail
// and count registers are updated at the accepting edge, the single RAM port
// is written (push) or read (pop) at that same edge, and the read data arrives
// in the next cycle in the result stage, which drives the output directly. A
// slot written at one edge is already visible to a read at the next, so no
// forwarding is needed. The result is offered in the cycle after acceptance;
// while a result is held by a stalled output, no new word is accepted, since
// the RAM read register belongs to that result. No clearing pass is needed
// after reset: a pop only ever reads a slot that an earlier push wrote.
// ----------------------------------------------------------------------------
module circular_buffer_deque_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input word fields, lowest bit up: opcode[1:0], push_value[33:2], zero pad.
  input  wire logic [cbd_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Output word fields, lowest bit up: status[1:0], popped_value[33:2],
  // entry_count[37:34], zero pad.
  output logic [cbd_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i
);

  localparam logic [cbd_pkg::CountW-1:0] CountOne = cbd_pkg::CountW'(1);

  // Deque pointers and fill level.
  logic [cbd_pkg::AddrW-1:0]  head_q, head_d;
  logic [cbd_pkg::AddrW-1:0]  tail_q, tail_d;
  logic [cbd_pkg::CountW-1:0] count_q, count_d;

  // Result stage.
  logic                       res_valid_q;
  cbd_pkg::status_e           res_status_q, res_status_d;
  logic                       res_pop_q, res_pop_d;
  logic [cbd_pkg::CountW-1:0] res_count_q;

  // Decoded input word.
  cbd_pkg::op_e              op;
  logic [cbd_pkg::DataW-1:0] push_value;
  logic                      accept;

  // RAM access.
  logic                      ram_en;
  logic                      ram_we;
  logic [cbd_pkg::AddrW-1:0] ram_addr;
  logic [cbd_pkg::DataW-1:0] ram_rdata;
  logic [cbd_pkg::DataW-1:0] popped_value;

  assign op         = cbd_pkg::op_e'(s_axis_tdata_i[cbd_pkg::OpW-1:0]);
  assign push_value = s_axis_tdata_i[cbd_pkg::OpW +: cbd_pkg::DataW];

  // A new word may enter once the held result has gone or is leaving now.
  assign s_axis_tready_o = !res_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    res_status_d = cbd_pkg::ST_DONE;
    res_pop_d    = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    case (op)
      cbd_pkg::OP_PUSH_FRONT, cbd_pkg::OP_PUSH_REAR: begin
        if (count_q >= cbd_pkg::FullCount) begin
          res_status_d = cbd_pkg::ST_FULL;
        end else begin
          ram_en  = accept;
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (count_q == '0) begin
            // An empty deque restarts at slot zero.
            head_d   = '0;
            tail_d   = '0;
            ram_addr = '0;
          end else if (op == cbd_pkg::OP_PUSH_FRONT) begin
            head_d   = cbd_pkg::step_down(head_q);
            ram_addr = head_d;
          end else begin
            tail_d   = cbd_pkg::step_up(tail_q);
            ram_addr = tail_d;
          end
        end
      end
      cbd_pkg::OP_POP_FRONT, cbd_pkg::OP_POP_REAR: begin
        if (count_q == '0) begin
          res_status_d = cbd_pkg::ST_EMPTY;
        end else begin
          ram_en    = accept;
          res_pop_d = 1'b1;
          count_d   = count_q - 1'b1;
          if (op == cbd_pkg::OP_POP_FRONT) begin
            ram_addr = head_q;
            // The last entry leaves both pointers where they are.
            if (count_q > CountOne) begin
              head_d = cbd_pkg::step_up(head_q);
            end
          end else begin
            ram_addr = tail_q;
            if (count_q > CountOne) begin
              tail_d = cbd_pkg::step_down(tail_q);
            end
          end
        end
      end
      default: begin
        res_status_d = cbd_pkg::ST_DONE;
      end
    endcase
  end

  cbd_ram #(
    .Width (cbd_pkg::DataW),
    .Depth (cbd_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (push_value),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= res_status_d;
      res_pop_q    <= res_pop_d;
      res_count_q  <= count_d;
    end
  end

  assign popped_value = res_pop_q ? ram_rdata : '0;

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = cbd_pkg::OutTdataW'({
                             cbd_pkg::EntryW'(res_count_q),
                             popped_value,
                             res_status_q
                           });

endmodule
`default_nettype wire

/* design/cbd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    en_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* tb/deque_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both stream channels of the deque, predicts each result word and
// compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module deque_checker
  import cbd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [InTdataW-1:0]  s_tdata_i,
  input  wire logic                 s_tvalid_i,
  input  wire logic                 s_tready_i,
  input  wire logic [OutTdataW-1:0] m_tdata_i,
  input  wire logic                 m_tvalid_i,
  input  wire logic                 m_tready_i,
  output int unsigned               fail_count_o,
  output int unsigned               outstanding_o
);

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped;
    logic [EntryW-1:0]  entries;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers.
  logic signed [31:0] shadow_slots [Depth];
  logic [AddrW-1:0]   front_slot;
  logic [AddrW-1:0]   back_slot;
  int unsigned        fill_level;

  deque_result_t      pending_results [$];
  int unsigned        reported;

  // Applies one operation to the shadow deque and returns the result word
  // that the unit should produce for it.
  function automatic deque_result_t apply_deque_op(input op_e op,
                                                   input logic signed [31:0] value);
    deque_result_t res;
    res.status = ST_DONE;
    res.popped = '0;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (fill_level >= Depth) begin
        res.status = ST_FULL;
      end else begin
        if (fill_level == 0) begin
          front_slot = '0;
          back_slot  = '0;
        end else if (op == OP_PUSH_FRONT) begin
          front_slot = (front_slot == 0) ? AddrW'(Depth - 1) : AddrW'(front_slot - 1);
        end else begin
          back_slot = (back_slot == AddrW'(Depth - 1)) ? '0 : AddrW'(back_slot + 1);
        end
        shadow_slots[(op == OP_PUSH_FRONT) ? front_slot : back_slot] = value;
        fill_level++;
      end
    end else begin
      if (fill_level == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // The last pop leaves both pointers where they were.
        if (op == OP_POP_FRONT) begin
          res.popped = shadow_slots[front_slot];
          if (fill_level > 1)
            front_slot = (front_slot == AddrW'(Depth - 1)) ? '0 : AddrW'(front_slot + 1);
        end else begin
          res.popped = shadow_slots[back_slot];
          if (fill_level > 1)
            back_slot = (back_slot == 0) ? AddrW'(Depth - 1) : AddrW'(back_slot - 1);
        end
        fill_level--;
      end
    end
    res.entries = EntryW'(fill_level);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    deque_result_t got;
    if (!rst_ni) begin
      front_slot = '0;
      back_slot  = '0;
      fill_level = 0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      pending_results.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
      reported      = 0;
    end else begin
      // The result leaving now belongs to an earlier word, so it is checked
      // before the word accepted at this edge is predicted.
      if (m_tvalid_i && m_tready_i) begin
        got.status  = status_e'(m_tdata_i[1:0]);
        got.popped  = m_tdata_i[33:2];
        got.entries = m_tdata_i[37:34];
        if (pending_results.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (reported < 10) begin
            reported++;
            $display("%0t: result word with none expected: status %0d popped %0d count %0d",
                     $realtime, got.status, got.popped, got.entries);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch: status exp %0d got %0d, popped exp %0d got %0d, count exp %0d got %0d",
                       $realtime, want.status, got.status, want.popped, got.popped,
                       want.entries, got.entries);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        pending_results.push_back(apply_deque_op(op_e'(s_tdata_i[1:0]), s_tdata_i[33:2]));
      outstanding_o <= pending_results.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the circular buffer deque unit.
// ----------------------------------------------------------------------------
// A directed sequence first walks the deque through empty pops, pushes into an
// empty deque, front pointer wrap in both directions, filling to full, refused pushes and
// draining from both ends. Random phases then follow, each leaning towards
// pushes, pops or a balance, so that the fill level keeps sweeping between
// empty and full. Both stream sides idle at random between words, with quiet
// stretches where they do not idle at all. The checker beside the unit
// predicts every result word and counts the failures.
// ----------------------------------------------------------------------------
module tb;
  import cbd_pkg::*;

  localparam int unsigned RandomWords = 750;

  logic                 clk_i;
  logic                 rst_ni;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  int unsigned          fail_count;
  int unsigned          outstanding;

  // When set, the sending side puts no gap between words (tx) or the receiving side no stall (rx).
  bit                   tx_quiet;
  bit                   rx_quiet;

  circular_buffer_deque_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  deque_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tdata_i     (s_axis_tdata),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offers one word after a random gap and returns at the falling edge that
  // follows its acceptance. The valid is left high so that back-to-back words
  // need no second assignment in one time step.
  task automatic send_word(input op_e op, input logic [31:0] value);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= InTdataW'({value, op});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly arbitrary words, with the extremes of the signed range and the
  // all-zero and all-one patterns mixed in.
  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Receiving side: stalls for a random number of cycles before each result
  // word, and now and then switches into a stretch with no stalls.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    rx_quiet      = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    op_e         op;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    tx_quiet      = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Pops from an empty deque are refused at both ends.
    send_word(OP_POP_FRONT, 32'h1111_1111);
    send_word(OP_POP_REAR,  32'h2222_2222);
    // A push into an empty deque lands in slot zero, and popping it from the
    // other end leaves the deque empty again.
    send_word(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_word(OP_POP_REAR,   32'h0);
    // Fill to full from both ends; the first front push wraps below slot zero.
    send_word(OP_PUSH_REAR,  32'h8000_0000);
    send_word(OP_PUSH_FRONT, 32'hffff_ffff);
    send_word(OP_PUSH_REAR,  32'h0000_0000);
    send_word(OP_PUSH_FRONT, 32'h5555_5555);
    send_word(OP_PUSH_REAR,  32'haaaa_aaaa);
    send_word(OP_PUSH_FRONT, 32'h0000_0001);
    send_word(OP_PUSH_REAR,  32'h1234_5678);
    send_word(OP_PUSH_FRONT, 32'hdead_beef);
    // Both kinds of push are refused while full.
    send_word(OP_PUSH_FRONT, 32'hcafe_f00d);
    send_word(OP_PUSH_REAR,  32'h0bad_cafe);
    // Drain from alternate ends down to empty, then one more refused pop.
    repeat (4) begin
      send_word(OP_POP_FRONT, 32'hffff_ffff);
      send_word(OP_POP_REAR,  32'h0);
    end
    send_word(OP_POP_FRONT, 32'h0);

    // Random phases, each biased towards pushes, pops or neither.
    sent = 0;
    while (sent < RandomWords) begin
      phase_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (sent < RandomWords) begin
          if ($urandom_range(0, 99) < push_pct)
            op = op_e'($urandom_range(0, 1));
          else
            op = op_e'($urandom_range(2, 3));
          send_word(op, draw_value());
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every predicted result, then give stray words time to show.
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Even with the longest gaps and stalls on every word the run needs well
  // under a third of this.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
